FILE: rtl/core/sei_message_deframer_defines.svh
// assertion macros used by the deframer rtl
`ifndef SEI_MESSAGE_DEFRAMER_DEFINES_SVH
`define SEI_MESSAGE_DEFRAMER_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SEIDF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true out of reset
`define SEIDF_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/core/seidf_pkg.sv
`timescale 1ns / 1ps
package seidf_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int OUT_WIDTH = 16;

	localparam logic [COUNT_WIDTH-1:0] CNT_GUARD =
		COUNT_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd256);
	localparam logic [7:0] EXT_BYTE = 8'hFF;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		PH_TYPE    = 2'd0,
		PH_SIZE    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_TRUNC    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		kind_t                kind;
		logic [OUT_WIDTH-1:0] msg_type;
		logic [OUT_WIDTH-1:0] msg_size;
		logic [7:0]           payload_byte;
		logic [OUT_WIDTH-1:0] byte_offset;
		logic                 last_of_payload;
		status_t              status;
	} out_word_t;

endpackage

FILE: rtl/core/seidf_parser.sv
`timescale 1ns / 1ps
module seidf_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  seidf_pkg::in_word_t word,
	output logic                emit,
	output seidf_pkg::out_word_t res
);
	import seidf_pkg::*;

	phase_t phase_q, phase_d;
	count_t type_sum_q, type_sum_d;
	count_t size_sum_q, size_sum_d;
	count_t remain_q, remain_d;
	count_t offset_q, offset_d;
	logic   drop_q, drop_d;

	count_t type_add;
	count_t size_add;
	logic   last;
	logic   ends;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			type_sum_q <= '0;
			size_sum_q <= '0;
			remain_q   <= '0;
			offset_q   <= '0;
			drop_q     <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			type_sum_q <= type_sum_d;
			size_sum_q <= size_sum_d;
			remain_q   <= remain_d;
			offset_q   <= offset_d;
			drop_q     <= drop_d;
		end
	end

	always_comb begin
		last     = word.last_byte;
		type_add = type_sum_q + count_t'(word.data_byte);
		size_add = size_sum_q + count_t'(word.data_byte);
		ends     = (remain_q <= count_t'(1));

		phase_d    = phase_q;
		type_sum_d = type_sum_q;
		size_sum_d = size_sum_q;
		remain_d   = remain_q;
		offset_d   = offset_q;
		drop_d     = drop_q;

		emit                = 1'b0;
		res.kind            = KIND_STATUS;
		res.msg_type        = '0;
		res.msg_size        = '0;
		res.payload_byte    = '0;
		res.byte_offset     = '0;
		res.last_of_payload = 1'b0;
		res.status          = ST_OK;

		if (drop_q) begin
			if (last) begin
				phase_d    = PH_TYPE;
				type_sum_d = '0;
				size_sum_d = '0;
				remain_d   = '0;
				offset_d   = '0;
				drop_d     = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_SIZE: begin
					if (size_sum_q > CNT_GUARD) begin
						emit       = 1'b1;
						res.status = ST_OVERFLOW;
					end else if (word.data_byte == EXT_BYTE) begin
						size_sum_d = size_add;
						if (last) begin
							emit       = 1'b1;
							res.status = ST_TRUNC;
						end
					end else if (size_add == '0) begin
						emit                = 1'b1;
						res.kind            = KIND_HEADER;
						res.msg_type        = OUT_WIDTH'(type_sum_q);
						res.last_of_payload = 1'b1;
						res.status          = last ? ST_COMPLETE : ST_OK;
						phase_d             = PH_TYPE;
						type_sum_d          = '0;
						size_sum_d          = '0;
						remain_d            = '0;
						offset_d            = '0;
					end else if (last) begin
						emit       = 1'b1;
						res.status = ST_TRUNC;
					end else begin
						emit         = 1'b1;
						res.kind     = KIND_HEADER;
						res.msg_type = OUT_WIDTH'(type_sum_q);
						res.msg_size = OUT_WIDTH'(size_add);
						phase_d      = PH_PAYLOAD;
						size_sum_d   = size_add;
						remain_d     = size_add;
						offset_d     = '0;
					end
				end
				PH_PAYLOAD: begin
					emit                = 1'b1;
					res.kind            = KIND_PAYLOAD;
					res.msg_type        = OUT_WIDTH'(type_sum_q);
					res.msg_size        = OUT_WIDTH'(size_sum_q);
					res.payload_byte    = word.data_byte;
					res.byte_offset     = OUT_WIDTH'(offset_q);
					res.last_of_payload = ends;
					if (ends) begin
						res.status = last ? ST_COMPLETE : ST_OK;
					end else begin
						res.status = last ? ST_TRUNC : ST_OK;
					end
					if (ends || last) begin
						phase_d    = PH_TYPE;
						type_sum_d = '0;
						size_sum_d = '0;
						remain_d   = '0;
						offset_d   = '0;
					end else begin
						remain_d = remain_q - count_t'(1);
						offset_d = offset_q + count_t'(1);
					end
				end
				default: begin
					phase_d = PH_TYPE;
					if (type_sum_q > CNT_GUARD) begin
						emit       = 1'b1;
						res.status = ST_OVERFLOW;
					end else if (last) begin
						emit       = 1'b1;
						res.status = ST_TRUNC;
					end else begin
						type_sum_d = type_add;
						if (word.data_byte != EXT_BYTE) begin
							phase_d = PH_SIZE;
						end
					end
				end
			endcase

			// any status marker is an error: clear the message and drop to region end
			if (emit && res.kind == KIND_STATUS) begin
				phase_d    = PH_TYPE;
				type_sum_d = '0;
				size_sum_d = '0;
				remain_d   = '0;
				offset_d   = '0;
				drop_d     = !last;
			end
		end
	end

endmodule

FILE: rtl/core/sei_message_deframer.sv
`timescale 1ns / 1ps
// SEI message deframer. Bytes of one SEI payload region arrive one word per cycle while
// item_stall is low, the final byte marked with last_byte. Each byte passes an input
// register and a result register, so the block takes a new word in every cycle unless
// the result side stalls, and a result is registered from its accepted byte; throughput
// is one byte per cycle, limited only by result-side stalls. Each message yields a header
// word (type and size), then one word per payload byte with its offset. A region that
// ends early gives a status word marked truncated, a header sum that would leave the
// counter range gives overflow, and after either the block discards bytes up to the end
// of the region. Type bytes, size extension bytes and dropped bytes give no result.
`include "sei_message_deframer_defines.svh"
module sei_message_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  seidf_pkg::in_word_t  item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output seidf_pkg::out_word_t result
);
	import seidf_pkg::*;

	logic      valid_s1;
	in_word_t  item_s1;
	logic      result_valid_q;
	out_word_t result_q;
	logic      out_take;
	logic      step;
	logic      emit;
	out_word_t res;

	assign out_take   = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !out_take;
	assign step       = valid_s1 && out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	seidf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.word   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_take) begin
			result_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`SEIDF_ASSERT(a_stall_needs_word, item_stall |-> valid_s1 && result_valid, "stall without a pending word")
	`SEIDF_ASSERT(a_status_is_error, result_valid && result.kind == KIND_STATUS |-> result.status == ST_TRUNC || result.status == ST_OVERFLOW, "status marker without error")
	`SEIDF_NEVER(a_empty_header, result_valid && result.kind == KIND_HEADER && result.last_of_payload && result.msg_size != '0, "header ends message with nonzero size")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import seidf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES = 450;
	localparam int MAX_REPORTS = 100;

	class deframe_scoreboard;
		out_word_t expected_words[$];
		int errors;
		phase_t phase;
		count_t type_acc;
		count_t size_acc;
		count_t left_in_payload;
		count_t offset_acc;
		logic discarding;

		function new();
			errors = 0;
			discarding = 1'b0;
			clear_message();
		endfunction

		function void clear_message();
			phase = PH_TYPE;
			type_acc = '0;
			size_acc = '0;
			left_in_payload = '0;
			offset_acc = '0;
		endfunction

		function void push_expected(kind_t k, count_t ty, count_t sz, logic [7:0] b,
				count_t off, logic lp, status_t st);
			out_word_t w;
			w = '0;
			w.kind = k;
			w.msg_type = OUT_WIDTH'(ty);
			w.msg_size = OUT_WIDTH'(sz);
			w.payload_byte = b;
			w.byte_offset = OUT_WIDTH'(off);
			w.last_of_payload = lp;
			w.status = st;
			expected_words.push_back(w);
		endfunction

		// error word, then either straight back to reset or discard to end of region
		function void abort_message(status_t st, logic last);
			push_expected(KIND_STATUS, '0, '0, 8'd0, '0, 1'b0, st);
			clear_message();
			discarding = !last;
		endfunction

		function void note_byte(in_word_t w);
			logic ends;
			status_t st;
			if (discarding) begin
				if (w.last_byte) begin
					clear_message();
					discarding = 1'b0;
				end
				return;
			end
			case (phase)
				PH_SIZE: begin
					if (size_acc > CNT_GUARD) begin
						abort_message(ST_OVERFLOW, w.last_byte);
						return;
					end
					size_acc = size_acc + count_t'(w.data_byte);
					if (w.data_byte == EXT_BYTE) begin
						if (w.last_byte)
							abort_message(ST_TRUNC, 1'b1);
						return;
					end
					if (size_acc == '0) begin
						push_expected(KIND_HEADER, type_acc, '0, 8'd0, '0, 1'b1,
							w.last_byte ? ST_COMPLETE : ST_OK);
						clear_message();
						return;
					end
					if (w.last_byte) begin
						abort_message(ST_TRUNC, 1'b1);
						return;
					end
					push_expected(KIND_HEADER, type_acc, size_acc, 8'd0, '0, 1'b0, ST_OK);
					phase = PH_PAYLOAD;
					left_in_payload = size_acc;
					offset_acc = '0;
				end
				PH_PAYLOAD: begin
					ends = (left_in_payload <= 1);
					if (ends)
						st = w.last_byte ? ST_COMPLETE : ST_OK;
					else
						st = w.last_byte ? ST_TRUNC : ST_OK;
					push_expected(KIND_PAYLOAD, type_acc, size_acc, w.data_byte, offset_acc,
						ends, st);
					if (ends || w.last_byte) begin
						clear_message();
					end else begin
						left_in_payload = left_in_payload - 1'b1;
						offset_acc = offset_acc + 1'b1;
					end
				end
				default: begin
					phase = PH_TYPE;
					if (type_acc > CNT_GUARD) begin
						abort_message(ST_OVERFLOW, w.last_byte);
						return;
					end
					type_acc = type_acc + count_t'(w.data_byte);
					if (w.last_byte) begin
						abort_message(ST_TRUNC, 1'b1);
						return;
					end
					if (w.data_byte != EXT_BYTE)
						phase = PH_SIZE;
				end
			endcase
		endfunction

		task flag_mismatch(string msg);
			if (errors < MAX_REPORTS)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				flag_mismatch($sformatf("word with nothing outstanding: %p", got));
				return;
			end
			want = expected_words.pop_front();
			compare_field("kind", 16'(got.kind), 16'(want.kind));
			compare_field("msg_type", got.msg_type, want.msg_type);
			compare_field("msg_size", got.msg_size, want.msg_size);
			compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
			compare_field("byte_offset", got.byte_offset, want.byte_offset);
			compare_field("last_of_payload", 16'(got.last_of_payload),
				16'(want.last_of_payload));
			compare_field("status", 16'(got.status), 16'(want.status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_word_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_word_t result;

	deframe_scoreboard tracker = new();
	logic no_idle = 1'b0;
	int stall_run = 0;
	int idle_cycles = 0;
	int sent_count = 0;

	sei_message_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver holds off in runs of random length
	always @(negedge clk) begin
		if (no_idle) begin
			result_stall = 1'b0;
			stall_run = 0;
		end else if (stall_run > 0) begin
			stall_run--;
		end else begin
			result_stall = ($urandom_range(0, 2) == 0);
			stall_run = result_stall ? idle_length() - 1 : $urandom_range(0, 8);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_word(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
		if (gap > 0) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item.data_byte = b;
		item.last_byte = last;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		tracker.note_byte(item);
		sent_count++;
	endtask

	task automatic send_region(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid = 1'b0;
		while (tracker.expected_words.size() != 0) @(posedge clk);
	endtask

	function automatic void push_sum(ref logic [7:0] q[$], input int value);
		while (value >= 255) begin
			q.push_back(EXT_BYTE);
			value -= 255;
		end
		q.push_back(8'(value));
	endfunction

	function automatic int pick_type();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 254);
		if (r < 99)
			return $urandom_range(255, 800);
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 6);
		if (r < 97)
			return $urandom_range(7, 40);
		return $urandom_range(250, 300);
	endfunction

	function automatic void add_messages(ref logic [7:0] q[$], input int count);
		int sz;
		repeat (count) begin
			push_sum(q, pick_type());
			sz = pick_size();
			push_sum(q, sz);
			repeat (sz) q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		logic [7:0] q[$];
		int start;
		int r;
		int keep;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// two messages, the second empty and closing the region
		send_region('{8'h05, 8'h02, 8'h00, 8'hFF, 8'h00, 8'h00});
		// extended type, single payload byte closing the region
		send_region('{8'hFF, 8'h10, 8'h01, 8'hAA});
		// region ends inside a payload
		send_region('{8'h01, 8'h03, 8'h11, 8'h22});
		// region ends in type, in extended size, on a non-empty size, and in extended type
		send_region('{8'h02});
		send_region('{8'h03, 8'hFF});
		send_region('{8'h04, 8'h05});
		send_region('{8'hFF});
		settle();

		// type overflow on the final byte
		q = {};
		repeat (257) q.push_back(EXT_BYTE);
		q.push_back(8'h00);
		send_region(q);
		// type exactly at the guard, then size overflow with bytes dropped after it
		q = {};
		repeat (256) q.push_back(EXT_BYTE);
		q.push_back(8'h00);
		repeat (257) q.push_back(EXT_BYTE);
		q.push_back(8'h07);
		q.push_back(8'h33);
		q.push_back(8'h44);
		send_region(q);
		settle();

		start = sent_count;
		while (sent_count - start < RANDOM_BYTES) begin
			no_idle = ($urandom_range(0, 99) < 15);
			q = {};
			r = $urandom_range(0, 99);
			if (r < 65) begin
				add_messages(q, $urandom_range(1, 4));
			end else if (r < 85) begin
				add_messages(q, $urandom_range(1, 3));
				if (q.size() > 1) begin
					keep = $urandom_range(1, q.size() - 1);
					q = q[0:keep-1];
				end
			end else begin
				repeat ($urandom_range(1, 12))
					q.push_back(($urandom_range(0, 9) < 3) ? EXT_BYTE :
						8'($urandom_range(0, 255)));
			end
			send_region(q);
			if ($urandom_range(0, 99) < 5)
				settle();
		end
		no_idle = 1'b0;

		settle();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/seidf_pkg.sv
rtl/core/seidf_parser.sv
rtl/core/sei_message_deframer.sv
sim/testbench.sv
